/* hw/rtl/stsum_pkg.sv */
`default_nettype none

package stsum_pkg;

	// Width of the element count register and its value after reset.
	localparam int unsigned COUNT_W       = 11;
	localparam int unsigned INDEX_W       = 10;
	localparam int unsigned DATA_W        = 32;
	localparam int unsigned SIZE_DEFAULT  = 1024;
	localparam logic [COUNT_W-1:0] ACTIVE_COUNT_RESET = 11'd1024;

	typedef enum logic [1:0] {
		MODE_SET   = 2'd0,
		MODE_ADD   = 2'd1,
		MODE_QUERY = 2'd2,
		MODE_NONE  = 2'd3
	} mode_t;

	typedef struct packed {
		mode_t                     mode;
		logic [INDEX_W-1:0]        index_low;
		logic [INDEX_W-1:0]        index_high;
		logic signed [DATA_W-1:0]  value;
	} item_t;

	typedef struct packed {
		logic signed [DATA_W-1:0]  range_sum;
		logic                      ignored;
	} result_t;

	typedef enum logic [3:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_DECODE,
		ST_LEAF_RD,
		ST_LEAF_WR,
		ST_SIB_RD,
		ST_PAR_WR,
		ST_Q_LEFT,
		ST_Q_RIGHT,
		ST_DONE
	} state_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic clr_step;
		logic load;
		logic decode;
		logic leaf_rd;
		logic leaf_wr;
		logic sib_rd;
		logic par_wr;
		logic q_left;
		logic q_right;
	} cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic  clr_last;
		logic  out_of_range;
		logic  empty;
		logic  root;
		logic  walk_end;
		mode_t mode;
	} sts_t;

endpackage

`default_nettype wire

/* hw/rtl/stsum_ctrl.sv */
`default_nettype none

module stsum_ctrl (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           start,
	input  wire stsum_pkg::sts_t sts,
	output stsum_pkg::cmd_t     cmd,
	output logic                busy,
	output logic                done
);
	import stsum_pkg::*;

	state_t state_q;
	state_t state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		cmd     = '0;
		busy    = 1'b1;
		done    = 1'b0;
		unique case (state_q)
			ST_CLEAR: begin
				cmd.clr_step = 1'b1;
				if (sts.clr_last) begin
					state_d = ST_IDLE;
				end
			end
			ST_IDLE: begin
				busy = 1'b0;
				if (start) begin
					cmd.load = 1'b1;
					state_d  = ST_DECODE;
				end
			end
			ST_DECODE: begin
				cmd.decode = 1'b1;
				unique case (sts.mode)
					MODE_SET: begin
						state_d = sts.out_of_range ? ST_DONE : ST_LEAF_WR;
					end
					MODE_ADD: begin
						state_d = sts.out_of_range ? ST_DONE : ST_LEAF_RD;
					end
					MODE_QUERY: begin
						state_d = sts.empty ? ST_DONE : ST_Q_LEFT;
					end
					default: begin
						state_d = ST_DONE;
					end
				endcase
			end
			ST_LEAF_RD: begin
				cmd.leaf_rd = 1'b1;
				state_d     = ST_LEAF_WR;
			end
			ST_LEAF_WR: begin
				cmd.leaf_wr = 1'b1;
				state_d     = ST_SIB_RD;
			end
			ST_SIB_RD: begin
				if (sts.root) begin
					state_d = ST_DONE;
				end else begin
					cmd.sib_rd = 1'b1;
					state_d    = ST_PAR_WR;
				end
			end
			ST_PAR_WR: begin
				cmd.par_wr = 1'b1;
				state_d    = ST_SIB_RD;
			end
			ST_Q_LEFT: begin
				if (sts.walk_end) begin
					state_d = ST_DONE;
				end else begin
					cmd.q_left = 1'b1;
					state_d    = ST_Q_RIGHT;
				end
			end
			ST_Q_RIGHT: begin
				cmd.q_right = 1'b1;
				state_d     = ST_Q_LEFT;
			end
			ST_DONE: begin
				done    = 1'b1;
				state_d = ST_IDLE;
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

endmodule

`default_nettype wire

/* hw/rtl/stsum_dp.sv */
`default_nettype none

module stsum_dp #(
	parameter int unsigned SIZE = stsum_pkg::SIZE_DEFAULT
) (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire stsum_pkg::cmd_t                 cmd,
	output stsum_pkg::sts_t                      sts,
	input  wire stsum_pkg::item_t                request,
	input  wire logic                            cfg_we,
	input  wire logic [stsum_pkg::COUNT_W-1:0]   cfg_data,
	output stsum_pkg::result_t                   result
);
	import stsum_pkg::*;

	localparam int unsigned NODES = 2 * SIZE;
	localparam int unsigned NW    = $clog2(NODES);
	localparam int unsigned LW    = NW + 1;
	localparam int unsigned CW0   = $clog2(SIZE + 1);
	localparam int unsigned CW    = (CW0 > COUNT_W) ? CW0 : COUNT_W;

	logic [DATA_W-1:0]  tree_q [NODES];
	logic [DATA_W-1:0]  rd_q;

	item_t              item_q;
	logic [COUNT_W-1:0] active_count_q;
	logic [NW-1:0]      clr_q;
	logic [LW-1:0]      l_q;
	logic [LW-1:0]      r_q;
	logic [NW-1:0]      node_q;
	logic [DATA_W-1:0]  cur_q;
	logic [DATA_W-1:0]  acc_q;
	logic               ign_q;
	logic               pend_q;

	logic [CW-1:0]      count_eff;
	logic [CW-1:0]      lo_ext;
	logic [CW-1:0]      hi_ext;
	logic [CW-1:0]      last_idx;
	logic [CW-1:0]      end_idx;
	logic               out_of_range;
	logic               empty;
	logic [LW-1:0]      l_init;
	logic [LW-1:0]      r_init;
	logic [LW-1:0]      r_dec;

	logic               mem_we;
	logic               mem_re;
	logic [NW-1:0]      mem_addr;
	logic [DATA_W-1:0]  mem_wdata;
	logic [DATA_W-1:0]  leaf_val;
	logic [DATA_W-1:0]  parent_sum;

	// Decode of the held request against the effective element count.
	always_comb begin
		count_eff    = CW'(active_count_q);
		if (count_eff > CW'(SIZE)) begin
			count_eff = CW'(SIZE);
		end
		lo_ext       = CW'(item_q.index_low);
		hi_ext       = CW'(item_q.index_high);
		last_idx     = count_eff - CW'(1);
		end_idx      = (hi_ext < last_idx) ? hi_ext : last_idx;
		out_of_range = (lo_ext >= count_eff);
		empty        = (count_eff == '0) || (lo_ext > end_idx);
		l_init       = LW'(lo_ext) + LW'(SIZE);
		r_init       = LW'(end_idx) + LW'(SIZE) + LW'(1);
		r_dec        = r_q - LW'(1);
	end

	assign leaf_val   = (item_q.mode == MODE_ADD) ? (rd_q + DATA_W'(item_q.value))
	                                              : DATA_W'(item_q.value);
	assign parent_sum = cur_q + rd_q;

	// Single memory port: at most one command is active in any cycle.
	always_comb begin
		mem_we    = 1'b0;
		mem_re    = 1'b0;
		mem_addr  = clr_q;
		mem_wdata = '0;
		if (cmd.clr_step) begin
			mem_we = 1'b1;
		end else if (cmd.leaf_rd) begin
			mem_re   = 1'b1;
			mem_addr = l_q[NW-1:0];
		end else if (cmd.leaf_wr) begin
			mem_we    = 1'b1;
			mem_addr  = l_q[NW-1:0];
			mem_wdata = leaf_val;
		end else if (cmd.sib_rd) begin
			mem_re   = 1'b1;
			mem_addr = node_q ^ NW'(1);
		end else if (cmd.par_wr) begin
			mem_we    = 1'b1;
			mem_addr  = node_q >> 1;
			mem_wdata = parent_sum;
		end else if (cmd.q_left) begin
			mem_re   = l_q[0];
			mem_addr = l_q[NW-1:0];
		end else if (cmd.q_right) begin
			mem_re   = r_q[0];
			mem_addr = r_dec[NW-1:0];
		end
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			tree_q[mem_addr] <= mem_wdata;
		end
		if (mem_re) begin
			rd_q <= tree_q[mem_addr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_count_q <= ACTIVE_COUNT_RESET;
			clr_q          <= '0;
			pend_q         <= 1'b0;
		end else begin
			if (cfg_we) begin
				active_count_q <= cfg_data;
			end
			if (cmd.clr_step) begin
				clr_q <= clr_q + NW'(1);
			end
			pend_q <= (cmd.q_left && l_q[0]) || (cmd.q_right && r_q[0]);
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			item_q <= request;
			acc_q  <= '0;
		end else if (pend_q) begin
			acc_q <= acc_q + rd_q;
		end
		if (cmd.decode) begin
			ign_q <= ((item_q.mode == MODE_SET) || (item_q.mode == MODE_ADD)) && out_of_range;
			l_q   <= l_init;
			r_q   <= r_init;
		end else if (cmd.q_left) begin
			if (l_q[0]) begin
				l_q <= l_q + LW'(1);
			end
		end else if (cmd.q_right) begin
			l_q <= l_q >> 1;
			r_q <= r_q >> 1;
		end
		if (cmd.leaf_wr) begin
			cur_q  <= leaf_val;
			node_q <= l_q[NW-1:0];
		end else if (cmd.par_wr) begin
			cur_q  <= parent_sum;
			node_q <= node_q >> 1;
		end
	end

	always_comb begin
		sts.clr_last     = (clr_q == NW'(NODES - 1));
		sts.out_of_range = out_of_range;
		sts.empty        = empty;
		sts.root         = (node_q == NW'(1));
		sts.walk_end     = (l_q >= r_q);
		sts.mode         = item_q.mode;
	end

	assign result.range_sum = $signed(acc_q);
	assign result.ignored   = ign_q;

endmodule

`default_nettype wire

/* hw/rtl/segment_tree_range_sum_unit.sv */
// Range-sum tree over SIZE signed 32-bit elements with point set, point add and
// inclusive range queries. A request is taken on a clock edge where start is high
// and busy is low; exactly one result follows, shown for a single cycle with done
// high, and the receiver cannot stall it, so it must capture the result in that
// cycle. All partial sums live in one single-port node memory of 2*SIZE words,
// and every tree level costs two accesses to it; busy stays high through done,
// so a new request is taken only once the last one is through. A request that
// is ignored, empty or of the unused mode 3 goes from decode straight to done.
// After reset the block clears all 2*SIZE words of the node memory (2048 words
// at the default size), one word a cycle, with busy high; configuration writes
// are taken at all times.
`default_nettype none

module segment_tree_range_sum_unit #(
	parameter int unsigned SIZE = stsum_pkg::SIZE_DEFAULT
) (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire logic                            start,
	output logic                                 busy,
	input  wire stsum_pkg::item_t                request,
	output logic                                 done,
	output stsum_pkg::result_t                   result,
	input  wire logic                            cfg_valid,
	output logic                                 cfg_ready,
	input  wire logic [stsum_pkg::COUNT_W-1:0]   cfg_data
);
	import stsum_pkg::*;

	cmd_t cmd;
	sts_t sts;

	// The count register is a plain flop, so a configuration request is always
	// accepted in the cycle it is offered.
	assign cfg_ready = 1'b1;

	// The controller sequences the tree walk: the clearing pass, a leaf write and
	// the climb to the root for set and add, or the two-sided walk for a query.
	stsum_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.sts    (sts),
		.cmd    (cmd),
		.busy   (busy),
		.done   (done)
	);

	// The datapath holds the node memory, the walk pointers and the sum.
	stsum_dp #(
		.SIZE (SIZE)
	) u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd      (cmd),
		.sts      (sts),
		.request  (request),
		.cfg_we   (cfg_valid && cfg_ready),
		.cfg_data (cfg_data),
		.result   (result)
	);

endmodule

`default_nettype wire

/* tb/testbench.sv */
`default_nettype none

// Self-checking bench for the range-sum tree unit.
//
// An initial block builds the request stream phase by phase: a short directed
// set first, then random requests under a series of element counts that walk
// through the extremes (zero, one, the full size, values above the size, and a
// count lowered and then raised again). A clocked driver takes requests from a
// queue and presents them on the command port. A clocked monitor captures
// every done strobe. The bench predicts each result itself from a flat copy of
// the element array, so no tree is kept here: a query is just a wrapped sum over
// the clipped index range.
module testbench;
	timeunit 1ns;
	timeprecision 1ps;

	import stsum_pkg::*;

	// Cycles to let pass after the last result before the count changes or the
	// run ends.
	localparam int unsigned SETTLE_CYCLES  = 40;
	// Cycles without any handshake or result before the run is abandoned.
	localparam int unsigned STALL_LIMIT    = 20000;
	localparam int unsigned REPORT_LIMIT   = 10;
	localparam int unsigned ELEMENTS       = SIZE_DEFAULT;
	localparam int unsigned PHASES         = 9;

	logic                 clk;
	logic                 arst_n     = 1'b0;
	logic                 start      = 1'b0;
	logic                 busy;
	item_t                request    = '0;
	logic                 done;
	result_t              result;
	logic                 cfg_valid  = 1'b0;
	logic                 cfg_ready;
	logic [COUNT_W-1:0]   cfg_data   = '0;

	// The bench's own copy of the element array and of the count register.
	logic [DATA_W-1:0]    element_value [ELEMENTS];
	logic [COUNT_W-1:0]   count_shadow = ACTIVE_COUNT_RESET;

	item_t                requests_queued[$];
	result_t              results_due[$];

	// Percentage of cycles in which the driver holds back a request it could
	// present. Changed only between phases.
	int unsigned          sender_idle_pct = 0;
	int unsigned          fault_count     = 0;
	int unsigned          quiet_cycles    = 0;

	segment_tree_range_sum_unit dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (start),
		.busy      (busy),
		.request   (request),
		.done      (done),
		.result    (result),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_data  (cfg_data)
	);

	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	// Applies one accepted request to the element copy and returns the result it
	// must produce. Counts above the array size behave as the full size.
	function automatic result_t apply_request(input item_t req);
		result_t      res;
		int unsigned  in_use;
		int unsigned  last;
		logic [DATA_W-1:0] total;
		res    = '0;
		total  = '0;
		in_use = (count_shadow > ELEMENTS) ? ELEMENTS : count_shadow;
		case (req.mode)
			MODE_SET, MODE_ADD: begin
				if (req.index_low >= in_use) begin
					// Out-of-range element: nothing changes, the request is flagged.
					res.ignored = 1'b1;
				end else if (req.mode == MODE_SET) begin
					element_value[req.index_low] = req.value;
				end else begin
					element_value[req.index_low] = element_value[req.index_low] + req.value;
				end
			end
			MODE_QUERY: begin
				// The end of the range is clipped to the last element in use; a
				// start beyond that end, or no elements at all, gives zero.
				if (in_use > 0) begin
					last = (req.index_high < in_use - 1) ? req.index_high : in_use - 1;
					for (int unsigned i = req.index_low; i <= last; i++)
						total = total + element_value[i];
					res.range_sum = total;
				end
			end
			default: begin
				// The unused mode leaves everything alone and reports zero.
			end
		endcase
		return res;
	endfunction

	// Builds a random request aimed mostly at elements in use, so that sets and
	// adds land and later queries see them; a share goes anywhere in the index
	// space to hit the out-of-range and clipping paths.
	function automatic item_t random_request(input int unsigned in_use);
		item_t        req;
		int unsigned  pick;
		int unsigned  top;
		int unsigned  span_end;
		req.index_low  = 10'($urandom);
		req.index_high = 10'($urandom);
		req.value      = $urandom;
		top  = (in_use == 0) ? ELEMENTS - 1 : in_use - 1;
		pick = $urandom_range(99);
		if (pick < 35)
			req.mode = MODE_SET;
		else if (pick < 60)
			req.mode = MODE_ADD;
		else if (pick < 95)
			req.mode = MODE_QUERY;
		else
			req.mode = MODE_NONE;
		if (req.mode == MODE_SET || req.mode == MODE_ADD) begin
			case ($urandom_range(9))
				0: ;
				1, 2: req.index_low = 10'($urandom_range(top < 15 ? top : 15));
				default: req.index_low = 10'($urandom_range(top));
			endcase
			case ($urandom_range(7))
				0: begin
					case ($urandom_range(3))
						0: req.value = 32'sh7fff_ffff;
						1: req.value = 32'sh8000_0000;
						2: req.value = -32'sd1;
						default: req.value = '0;
					endcase
				end
				1: req.value = $signed(32'($urandom_range(200))) - 32'sd100;
				default: ;
			endcase
		end else if (req.mode == MODE_QUERY) begin
			case ($urandom_range(5))
				0: begin
					req.index_low  = '0;
					req.index_high = 10'(ELEMENTS - 1);
				end
				1: begin
					req.index_low  = 10'($urandom_range(top));
					span_end = req.index_low + $urandom_range(7);
					req.index_high = 10'((span_end > ELEMENTS - 1) ? ELEMENTS - 1 : span_end);
				end
				2: ;
				default: begin
					req.index_low  = 10'($urandom_range(top));
					req.index_high = 10'($urandom_range(ELEMENTS - 1, req.index_low));
				end
			endcase
		end
		return req;
	endfunction

	task automatic queue_request(input mode_t m, input int unsigned lo, input int unsigned hi,
			input logic [DATA_W-1:0] v);
		item_t req;
		req.mode       = m;
		req.index_low  = 10'(lo);
		req.index_high = 10'(hi);
		req.value      = v;
		requests_queued.push_back(req);
	endtask

	// Waits until every queued request has been taken and answered, then lets
	// the block settle. Checks are made on the falling edge, clear of the
	// clocked processes.
	task automatic wait_for_drain();
		do
			@(negedge clk);
		while (requests_queued.size() != 0 || start || results_due.size() != 0);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	// Writes the element count over the configuration channel and mirrors it.
	task automatic write_count(input logic [COUNT_W-1:0] new_count);
		@(posedge clk);
		cfg_valid <= 1'b1;
		cfg_data  <= new_count;
		do
			@(posedge clk);
		while (!cfg_ready);
		cfg_valid    <= 1'b0;
		count_shadow = new_count;
	endtask

	// Driver. A request is taken on an edge with start high and busy low; that
	// is where its result is predicted. A request on offer is held until taken,
	// and start is only ever assigned once per edge.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start   <= 1'b0;
			request <= '0;
		end else begin
			if (start && !busy)
				results_due.push_back(apply_request(request));
			if (!start || !busy) begin
				if (requests_queued.size() != 0 && $urandom_range(99) >= sender_idle_pct) begin
					request <= requests_queued.pop_front();
					start   <= 1'b1;
				end else begin
					start   <= 1'b0;
				end
			end
		end
	end

	// Monitor. Each result is shown for one cycle only, so it is captured on the
	// edge that ends that cycle and compared with the oldest prediction.
	always @(posedge clk) begin
		result_t want;
		if (arst_n && done) begin
			if (results_due.size() == 0) begin
				fault_count++;
				if (fault_count <= REPORT_LIMIT)
					$display("%0t: result with none outstanding: sum %0d ignored %0b",
						$realtime, result.range_sum, result.ignored);
			end else begin
				want = results_due.pop_front();
				if (result.range_sum !== want.range_sum || result.ignored !== want.ignored) begin
					fault_count++;
					if (fault_count <= REPORT_LIMIT)
						$display("%0t: mismatch: sum %0d ignored %0b, expected sum %0d ignored %0b",
							$realtime, result.range_sum, result.ignored,
							want.range_sum, want.ignored);
				end
			end
		end
	end

	// Watchdog: any request taken, result shown or register write resets it.
	always @(posedge clk) begin
		if ((start && !busy) || done || (cfg_valid && cfg_ready)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= STALL_LIMIT) begin
			$display("FAIL");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	initial begin
		// Count settings for the random phases: above the size, one, none, the
		// size lowered by one and then raised again, two, a middling value, a
		// random one, and the size itself at the end.
		logic [COUNT_W-1:0] phase_count [PHASES];
		int unsigned        phase_items [PHASES];
		int unsigned        idle_pattern [4];
		int unsigned        in_use;
		phase_count  = '{11'd2047, 11'd1, 11'd0, 11'd1023, 11'd1024, 11'd2, 11'd513, 11'd0,
			11'd1024};
		phase_items  = '{250, 60, 30, 250, 260, 80, 260, 260, 260};
		// No idling, a mostly idle sender, no idling again (the receiver cannot
		// hold results off), and a lightly idle sender.
		idle_pattern = '{0, 79, 0, 20};
		phase_count[7] = 11'($urandom_range(1, 2047));

		foreach (element_value[i])
			element_value[i] = '0;

		repeat (3) @(posedge clk);
		arst_n <= 1'b1;

		// Directed requests at the reset count. The first query sees the cleared
		// store; the two extreme values at both ends then sum to minus one and wrap
		// when added to, and a reversed range and the unused mode give zero.
		write_count(ACTIVE_COUNT_RESET);
		@(negedge clk);
		queue_request(MODE_QUERY, 0, ELEMENTS - 1, '0);
		queue_request(MODE_SET, 0, ELEMENTS - 1, 32'h7fff_ffff);
		queue_request(MODE_SET, ELEMENTS - 1, 0, 32'h8000_0000);
		queue_request(MODE_QUERY, 0, ELEMENTS - 1, 32'hffff_ffff);
		queue_request(MODE_ADD, 0, 0, 32'h0000_0001);
		queue_request(MODE_ADD, ELEMENTS - 1, ELEMENTS - 1, 32'hffff_ffff);
		queue_request(MODE_QUERY, 0, 0, '0);
		queue_request(MODE_QUERY, ELEMENTS - 1, ELEMENTS - 1, '0);
		queue_request(MODE_SET, 512, 341, 32'h5555_5555);
		queue_request(MODE_SET, 341, 512, 32'haaaa_aaaa);
		queue_request(MODE_ADD, 1, 1022, 32'h0000_0100);
		queue_request(MODE_QUERY, 1, ELEMENTS - 2, '0);
		queue_request(MODE_QUERY, 341, 512, 32'h1234_5678);
		queue_request(MODE_QUERY, 700, 3, '0);
		queue_request(MODE_NONE, 5, 9, 32'hdead_beef);
		queue_request(MODE_SET, 513, ELEMENTS - 1, 32'hffff_ffff);
		queue_request(MODE_ADD, 512, 0, 32'h8000_0000);
		queue_request(MODE_QUERY, 511, 514, 32'hffff_ffff);
		queue_request(MODE_NONE, ELEMENTS - 1, ELEMENTS - 1, 32'hffff_ffff);
		queue_request(MODE_QUERY, 0, ELEMENTS - 1, '0);
		wait_for_drain();

		for (int unsigned p = 0; p < PHASES; p++) begin
			write_count(phase_count[p]);
			@(negedge clk);
			sender_idle_pct = idle_pattern[p % 4];
			in_use = (phase_count[p] > ELEMENTS) ? ELEMENTS : phase_count[p];
			repeat (phase_items[p])
				requests_queued.push_back(random_request(in_use));
			wait_for_drain();
		end

		if (fault_count == 0 && results_due.size() == 0) begin
			$display("PASS");
		end else begin
			$display("FAIL");
		end
		$finish;
	end

endmodule

`default_nettype wire
